### rtl/core/alam_pkg.sv
// Shared types, register indexes and alarm codes of the averaged level alarm monitor.
package alam_pkg;

    localparam int MAX_AVERAGE_COUNT_DEF = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int LVL_W = 11;
    localparam int ADC_W = 12;
    localparam int ALARM_W = 3;
    localparam int AVG_CNT_W = 7;
    localparam int HYST_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_AVERAGING_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TOP         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ALARM       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_WARNING     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_NORMAL_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS        = 3'd5;

    localparam logic [ALARM_W-1:0] ALARM_NONE    = 3'd0;
    localparam logic [ALARM_W-1:0] ALARM_NORMAL  = 3'd2;
    localparam logic [ALARM_W-1:0] ALARM_HIGH    = 3'd3;
    localparam logic [ALARM_W-1:0] ALARM_WARNING = 3'd4;
    localparam logic [ALARM_W-1:0] ALARM_ALARM   = 3'd5;
    localparam logic [ALARM_W-1:0] ALARM_TOP     = 3'd6;

    typedef struct packed {
        logic [LVL_W-1:0] level_sample;
        logic [ADC_W-1:0] adc_sample;
        logic             relay_top;
        logic             relay_high;
        logic             relay_low;
    } item_t;

    typedef struct packed {
        logic               average_valid;
        logic [LVL_W-1:0]   level_average;
        logic [ADC_W-1:0]   adc_average;
        logic [ALARM_W-1:0] level_alarm_res;
        logic [ALARM_W-1:0] relay_alarm;
        logic [ALARM_W-1:0] alarm_state;
        logic               alarm_changed;
        logic               level_moved;
    } result_t;

    typedef struct packed {
        logic [AVG_CNT_W-1:0] averaging_count;
        logic [LVL_W-1:0]     level_top;
        logic [LVL_W-1:0]     level_alarm;
        logic [LVL_W-1:0]     level_warning;
        logic [LVL_W-1:0]     level_normal_high;
        logic [HYST_W-1:0]    hysteresis;
    } cfg_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_DONE
    } back_state_t;

endpackage

### rtl/core/alam_front.sv
// Front end: accumulates the sample sums, decides block completion and grades the relay contacts.
module alam_front
    import alam_pkg::*;
#(
    parameter int MAX_AVERAGE_COUNT = MAX_AVERAGE_COUNT_DEF,
    parameter int CNT_W = $clog2(MAX_AVERAGE_COUNT + 1),
    parameter int LSUM_W = LVL_W + $clog2(MAX_AVERAGE_COUNT),
    parameter int ASUM_W = ADC_W + $clog2(MAX_AVERAGE_COUNT)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [AVG_CNT_W-1:0] averaging_count,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  item_t                in_data,
    output logic                 job_valid,
    input  logic                 job_ready,
    output logic                 job_complete,
    output logic [LSUM_W-1:0]    job_level_sum,
    output logic [ASUM_W-1:0]    job_adc_sum,
    output logic [CNT_W-1:0]     job_count,
    output logic [ALARM_W-1:0]   job_relay
);

    localparam int CMP_W = (CNT_W > AVG_CNT_W) ? CNT_W : AVG_CNT_W;

    logic [LSUM_W-1:0] level_sum_reg, level_sum_next;
    logic [ASUM_W-1:0] adc_sum_reg, adc_sum_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CMP_W-1:0]  ac_ext;
    logic [CNT_W-1:0]  eff_count;
    logic [LSUM_W-1:0] lsum_new;
    logic [ASUM_W-1:0] asum_new;
    logic [CNT_W-1:0]  cnt_new;
    logic              complete;
    logic              accept;

    always_comb
    begin
        ac_ext = CMP_W'(averaging_count);
        if (ac_ext == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (ac_ext > CMP_W'(MAX_AVERAGE_COUNT))
        begin
            eff_count = CNT_W'(MAX_AVERAGE_COUNT);
        end
        else
        begin
            eff_count = ac_ext[CNT_W-1:0];
        end

        lsum_new = level_sum_reg + LSUM_W'(in_data.level_sample);
        asum_new = adc_sum_reg + ASUM_W'(in_data.adc_sample);
        cnt_new = count_reg + CNT_W'(1);
        complete = (cnt_new >= eff_count);

        if (!in_data.relay_top && !in_data.relay_high)
        begin
            job_relay = ALARM_ALARM;
        end
        else if (!in_data.relay_high)
        begin
            job_relay = ALARM_WARNING;
        end
        else if (in_data.relay_low)
        begin
            job_relay = ALARM_HIGH;
        end
        else
        begin
            job_relay = ALARM_NORMAL;
        end

        accept = in_valid && job_ready;
        level_sum_next = level_sum_reg;
        adc_sum_next = adc_sum_reg;
        count_next = count_reg;
        if (accept)
        begin
            level_sum_next = complete ? '0 : lsum_new;
            adc_sum_next = complete ? '0 : asum_new;
            count_next = complete ? '0 : cnt_new;
        end
    end

    assign in_ready = job_ready;
    assign job_valid = in_valid;
    assign job_complete = complete;
    assign job_level_sum = lsum_new;
    assign job_adc_sum = asum_new;
    assign job_count = eff_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_sum_reg <= '0;
            adc_sum_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            level_sum_reg <= level_sum_next;
            adc_sum_reg <= adc_sum_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/alam_fifo.sv
// Short job queue between the front end and the back end.
module alam_fifo
    import alam_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        push_ready = (fill_reg != FILL_W'(DEPTH));
        pop_valid = (fill_reg != '0);
        do_push = push_valid && push_ready;
        do_pop = pop_valid && pop_ready;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end

        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

### rtl/core/alam_back.sv
// Back end: divides the block sums, runs the level alarm ladder and holds the result beat.
module alam_back
    import alam_pkg::*;
#(
    parameter int MAX_AVERAGE_COUNT = MAX_AVERAGE_COUNT_DEF,
    parameter int CNT_W = $clog2(MAX_AVERAGE_COUNT + 1),
    parameter int LSUM_W = LVL_W + $clog2(MAX_AVERAGE_COUNT),
    parameter int ASUM_W = ADC_W + $clog2(MAX_AVERAGE_COUNT)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               job_valid,
    output logic               job_ready,
    input  logic               job_complete,
    input  logic [LSUM_W-1:0]  job_level_sum,
    input  logic [ASUM_W-1:0]  job_adc_sum,
    input  logic [CNT_W-1:0]   job_count,
    input  logic [ALARM_W-1:0] job_relay,
    output logic               out_valid,
    input  logic               out_ready,
    output result_t            out_data
);

    localparam int STEP_W = $clog2(ASUM_W);
    localparam int SW = LVL_W + 2;

    back_state_t state_reg, state_next;

    logic               complete_reg, complete_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [ALARM_W-1:0] relay_reg, relay_next;
    logic [ASUM_W-1:0]  lq_reg, lq_next;
    logic [ASUM_W-1:0]  aq_reg, aq_next;
    logic [CNT_W-1:0]   lr_reg, lr_next;
    logic [CNT_W-1:0]   ar_reg, ar_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [LVL_W-1:0]   held_level_reg, held_level_next;
    logic [ADC_W-1:0]   held_adc_reg, held_adc_next;
    logic [ALARM_W-1:0] lvl_alarm_reg, lvl_alarm_next;
    logic [ALARM_W-1:0] rly_alarm_reg, rly_alarm_next;
    logic [LVL_W-1:0]   last_noted_reg, last_noted_next;
    result_t            out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [CNT_W:0]     t_l;
    logic [CNT_W:0]     t_a;
    logic               ge_l;
    logic               ge_a;
    logic [LVL_W-1:0]   avg_l;
    logic [ADC_W-1:0]   avg_a;
    logic [ALARM_W-1:0] ladder;
    logic [ALARM_W-1:0] lvl_new;
    logic signed [SW-1:0] diff;
    logic               moved;
    logic               slot_free;

    function automatic logic rung(
        input logic [ALARM_W-1:0] cur,
        input logic [ALARM_W-1:0] lvl,
        input logic [LVL_W-1:0]   avg,
        input logic [LVL_W-1:0]   thr,
        input logic [HYST_W-1:0]  hyst
    );
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] t;
        a = signed'({2'b00, avg});
        t = signed'({2'b00, thr});
        if (cur < lvl)
        begin
            return a > t;
        end
        return a > (t - signed'(SW'(hyst)));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        t_l = {lr_reg, lq_reg[ASUM_W-1]};
        t_a = {ar_reg, aq_reg[ASUM_W-1]};
        ge_l = (t_l >= {1'b0, n_reg});
        ge_a = (t_a >= {1'b0, n_reg});

        avg_l = complete_reg ? lq_reg[LVL_W-1:0] : held_level_reg;
        avg_a = complete_reg ? aq_reg[ADC_W-1:0] : held_adc_reg;

        if (rung(lvl_alarm_reg, ALARM_TOP, avg_l, cfg.level_top, cfg.hysteresis))
        begin
            ladder = ALARM_TOP;
        end
        else if (rung(lvl_alarm_reg, ALARM_ALARM, avg_l, cfg.level_alarm, cfg.hysteresis))
        begin
            ladder = ALARM_ALARM;
        end
        else if (rung(lvl_alarm_reg, ALARM_WARNING, avg_l, cfg.level_warning,
                      cfg.hysteresis))
        begin
            ladder = ALARM_WARNING;
        end
        else if (rung(lvl_alarm_reg, ALARM_HIGH, avg_l, cfg.level_normal_high,
                      cfg.hysteresis))
        begin
            ladder = ALARM_HIGH;
        end
        else
        begin
            ladder = ALARM_NORMAL;
        end
        lvl_new = complete_reg ? ladder : lvl_alarm_reg;

        diff = signed'({2'b00, avg_l}) - signed'({2'b00, last_noted_reg});
        moved = complete_reg && ((diff > SW'(1)) || (diff < -SW'(1)));

        slot_free = !out_valid_reg || out_ready;

        state_next = state_reg;
        complete_next = complete_reg;
        n_next = n_reg;
        relay_next = relay_reg;
        lq_next = lq_reg;
        aq_next = aq_reg;
        lr_next = lr_reg;
        ar_next = ar_reg;
        step_next = step_reg;
        held_level_next = held_level_reg;
        held_adc_next = held_adc_reg;
        lvl_alarm_next = lvl_alarm_reg;
        rly_alarm_next = rly_alarm_reg;
        last_noted_next = last_noted_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        job_ready = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BS_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    complete_next = job_complete;
                    n_next = job_count;
                    relay_next = job_relay;
                    lq_next = {{(ASUM_W - LSUM_W){1'b0}}, job_level_sum};
                    aq_next = job_adc_sum;
                    lr_next = '0;
                    ar_next = '0;
                    step_next = STEP_W'(ASUM_W - 1);
                    state_next = job_complete ? BS_DIV : BS_DONE;
                end
            end
            BS_DIV:
            begin
                lr_next = ge_l ? CNT_W'(t_l - {1'b0, n_reg}) : t_l[CNT_W-1:0];
                ar_next = ge_a ? CNT_W'(t_a - {1'b0, n_reg}) : t_a[CNT_W-1:0];
                lq_next = {lq_reg[ASUM_W-2:0], ge_l};
                aq_next = {aq_reg[ASUM_W-2:0], ge_a};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = BS_DONE;
                end
            end
            BS_DONE:
            begin
                if (slot_free)
                begin
                    out_next.average_valid = complete_reg;
                    out_next.level_average = avg_l;
                    out_next.adc_average = avg_a;
                    out_next.level_alarm_res = lvl_new;
                    out_next.relay_alarm = relay_reg;
                    out_next.alarm_state = (lvl_new > relay_reg) ? lvl_new : relay_reg;
                    out_next.alarm_changed = (lvl_new != lvl_alarm_reg) ||
                                             (relay_reg != rly_alarm_reg);
                    out_next.level_moved = moved;
                    out_valid_next = 1'b1;
                    held_level_next = avg_l;
                    held_adc_next = avg_a;
                    lvl_alarm_next = lvl_new;
                    rly_alarm_next = relay_reg;
                    if (moved)
                    begin
                        last_noted_next = avg_l;
                    end
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk)
    begin
        complete_reg <= complete_next;
        n_reg <= n_next;
        relay_reg <= relay_next;
        lq_reg <= lq_next;
        aq_reg <= aq_next;
        lr_reg <= lr_next;
        ar_reg <= ar_next;
        step_reg <= step_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_level_reg <= '0;
            held_adc_reg <= '0;
            lvl_alarm_reg <= ALARM_NONE;
            rly_alarm_reg <= ALARM_NONE;
            last_noted_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_level_reg <= held_level_next;
            held_adc_reg <= held_adc_next;
            lvl_alarm_reg <= lvl_alarm_next;
            rly_alarm_reg <= rly_alarm_next;
            last_noted_reg <= last_noted_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/averaged_level_alarm_monitor_core.sv
// Top level of the averaged level alarm monitor: configuration registers, front end, queue, back end.
// Every accepted beat yields one result beat. A beat that closes an averaging block passes
// through the restoring divider, which produces one quotient bit per cycle for both averages
// at once; a beat that does not close one goes straight to the result. A two-entry queue lets
// the front end keep taking beats while the divider runs or the result waits, until it is full.
module averaged_level_alarm_monitor_core
    import alam_pkg::*;
#(
    parameter int MAX_AVERAGE_COUNT = MAX_AVERAGE_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  item_t                 in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output result_t               out_data
);

    localparam int CNT_W = $clog2(MAX_AVERAGE_COUNT + 1);
    localparam int LSUM_W = LVL_W + $clog2(MAX_AVERAGE_COUNT);
    localparam int ASUM_W = ADC_W + $clog2(MAX_AVERAGE_COUNT);
    localparam int JOB_W = 1 + LSUM_W + ASUM_W + CNT_W + ALARM_W;

    cfg_t cfg_reg, cfg_next;

    logic               f_valid;
    logic               f_ready;
    logic               f_complete;
    logic [LSUM_W-1:0]  f_level_sum;
    logic [ASUM_W-1:0]  f_adc_sum;
    logic [CNT_W-1:0]   f_count;
    logic [ALARM_W-1:0] f_relay;
    logic [JOB_W-1:0]   q_in;
    logic [JOB_W-1:0]   q_out;
    logic               b_valid;
    logic               b_ready;
    logic               b_complete;
    logic [LSUM_W-1:0]  b_level_sum;
    logic [ASUM_W-1:0]  b_adc_sum;
    logic [CNT_W-1:0]   b_count;
    logic [ALARM_W-1:0] b_relay;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_en)
        begin
            case (cfg_index)
                REG_AVERAGING_COUNT:   cfg_next.averaging_count = cfg_data[AVG_CNT_W-1:0];
                REG_LEVEL_TOP:         cfg_next.level_top = cfg_data[LVL_W-1:0];
                REG_LEVEL_ALARM:       cfg_next.level_alarm = cfg_data[LVL_W-1:0];
                REG_LEVEL_WARNING:     cfg_next.level_warning = cfg_data[LVL_W-1:0];
                REG_LEVEL_NORMAL_HIGH: cfg_next.level_normal_high = cfg_data[LVL_W-1:0];
                REG_HYSTERESIS:        cfg_next.hysteresis = cfg_data[HYST_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.averaging_count <= AVG_CNT_W'(10);
            cfg_reg.level_top <= LVL_W'(400);
            cfg_reg.level_alarm <= LVL_W'(350);
            cfg_reg.level_warning <= LVL_W'(300);
            cfg_reg.level_normal_high <= LVL_W'(200);
            cfg_reg.hysteresis <= HYST_W'(5);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    alam_front #(
        .MAX_AVERAGE_COUNT(MAX_AVERAGE_COUNT),
        .CNT_W(CNT_W),
        .LSUM_W(LSUM_W),
        .ASUM_W(ASUM_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .averaging_count(cfg_reg.averaging_count),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .job_valid(f_valid),
        .job_ready(f_ready),
        .job_complete(f_complete),
        .job_level_sum(f_level_sum),
        .job_adc_sum(f_adc_sum),
        .job_count(f_count),
        .job_relay(f_relay)
    );

    assign q_in = {f_complete, f_level_sum, f_adc_sum, f_count, f_relay};
    assign {b_complete, b_level_sum, b_adc_sum, b_count, b_relay} = q_out;

    alam_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(f_valid),
        .push_ready(f_ready),
        .push_data(q_in),
        .pop_valid(b_valid),
        .pop_ready(b_ready),
        .pop_data(q_out)
    );

    alam_back #(
        .MAX_AVERAGE_COUNT(MAX_AVERAGE_COUNT),
        .CNT_W(CNT_W),
        .LSUM_W(LSUM_W),
        .ASUM_W(ASUM_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .job_valid(b_valid),
        .job_ready(b_ready),
        .job_complete(b_complete),
        .job_level_sum(b_level_sum),
        .job_adc_sum(b_adc_sum),
        .job_count(b_count),
        .job_relay(b_relay),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

endmodule

### rtl/core/alam_checker.sv
// Port-level checks of the averaged level alarm monitor and their binding to the top level.
module alam_checker
    import alam_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input item_t   in_data,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_worst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.alarm_state >= out_data.level_alarm_res) &&
                      (out_data.alarm_state >= out_data.relay_alarm) &&
                      ((out_data.alarm_state == out_data.level_alarm_res) ||
                       (out_data.alarm_state == out_data.relay_alarm)))
        else $error("alarm state is not the worst of the two alarms");

    a_moved_only_on_average: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.average_valid |-> !out_data.level_moved)
        else $error("level moved without a new average");

    a_alarm_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.relay_alarm >= ALARM_NORMAL) &&
                      (out_data.relay_alarm <= ALARM_ALARM) &&
                      ((out_data.level_alarm_res == ALARM_NONE) ||
                       (out_data.level_alarm_res >= ALARM_NORMAL)) &&
                      (out_data.level_alarm_res <= ALARM_TOP))
        else $error("alarm code out of its range");

endmodule

bind averaged_level_alarm_monitor_core alam_checker u_alam_checker (.*);

### tb/sv/tb.sv
// Self-checking testbench for the averaged level alarm monitor core.
`timescale 1ns / 100ps

module tb;
    import alam_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    item_t                 in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    result_t               out_data;

    averaged_level_alarm_monitor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the configuration registers.
    logic [AVG_CNT_W-1:0] shadow_avg_count = AVG_CNT_W'(10);
    logic [LVL_W-1:0]     shadow_top = LVL_W'(400);
    logic [LVL_W-1:0]     shadow_alarm = LVL_W'(350);
    logic [LVL_W-1:0]     shadow_warning = LVL_W'(300);
    logic [LVL_W-1:0]     shadow_normal_high = LVL_W'(200);
    logic [HYST_W-1:0]    shadow_hyst = HYST_W'(5);

    // Predicted internal state of the monitor.
    int unsigned          level_acc = 0;
    int unsigned          adc_acc = 0;
    int unsigned          samples_in_block = 0;
    logic [LVL_W-1:0]     avg_level_q = '0;
    logic [ADC_W-1:0]     avg_adc_q = '0;
    logic [ALARM_W-1:0]   level_alarm_q = ALARM_NONE;
    logic [ALARM_W-1:0]   relay_alarm_q = ALARM_NONE;
    logic [LVL_W-1:0]     noted_level_q = '0;

    item_t   samples_to_send[$];
    result_t alarm_reports_due[$];

    int  samples_queued = 0;
    int  samples_taken = 0;
    int  reports_seen = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    bit  in_taken = 1'b0;
    bit  no_idle = 1'b0;
    int  send_gap = 0;
    bit  drain_pending = 1'b0;
    int  stall_left = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
        begin
            return 0;
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic bit rung_reached(logic [ALARM_W-1:0] cur, logic [ALARM_W-1:0] rung,
                                        int avg, int thr);
        if (cur < rung)
        begin
            return avg > thr;
        end
        return avg > thr - int'(shadow_hyst);
    endfunction

    function automatic logic [ALARM_W-1:0] next_level_alarm(logic [ALARM_W-1:0] cur,
                                                           logic [LVL_W-1:0] avg_u);
        int avg;
        avg = int'(avg_u);
        if (rung_reached(cur, ALARM_TOP, avg, int'(shadow_top)))
        begin
            return ALARM_TOP;
        end
        if (rung_reached(cur, ALARM_ALARM, avg, int'(shadow_alarm)))
        begin
            return ALARM_ALARM;
        end
        if (rung_reached(cur, ALARM_WARNING, avg, int'(shadow_warning)))
        begin
            return ALARM_WARNING;
        end
        if (rung_reached(cur, ALARM_HIGH, avg, int'(shadow_normal_high)))
        begin
            return ALARM_HIGH;
        end
        return ALARM_NORMAL;
    endfunction

    function automatic result_t advance_level_monitor(item_t smp);
        result_t            rep;
        int unsigned        n;
        int                 diff;
        logic [ALARM_W-1:0] old_level;
        logic [ALARM_W-1:0] old_relay;
        rep = '0;
        old_level = level_alarm_q;
        old_relay = relay_alarm_q;
        level_acc += smp.level_sample;
        adc_acc += smp.adc_sample;
        samples_in_block++;
        if (shadow_avg_count == 0)
        begin
            n = 1;
        end
        else if (shadow_avg_count > MAX_AVERAGE_COUNT_DEF)
        begin
            n = MAX_AVERAGE_COUNT_DEF;
        end
        else
        begin
            n = shadow_avg_count;
        end
        if (samples_in_block >= n)
        begin
            avg_level_q = LVL_W'(level_acc / n);
            avg_adc_q = ADC_W'(adc_acc / n);
            level_acc = 0;
            adc_acc = 0;
            samples_in_block = 0;
            rep.average_valid = 1'b1;
            diff = int'(avg_level_q) - int'(noted_level_q);
            if (diff > 1 || diff < -1)
            begin
                rep.level_moved = 1'b1;
                noted_level_q = avg_level_q;
            end
            level_alarm_q = next_level_alarm(level_alarm_q, avg_level_q);
        end
        if (!smp.relay_top && !smp.relay_high)
        begin
            relay_alarm_q = ALARM_ALARM;
        end
        else if (!smp.relay_high)
        begin
            relay_alarm_q = ALARM_WARNING;
        end
        else if (smp.relay_low)
        begin
            relay_alarm_q = ALARM_HIGH;
        end
        else
        begin
            relay_alarm_q = ALARM_NORMAL;
        end
        rep.level_average = avg_level_q;
        rep.adc_average = avg_adc_q;
        rep.level_alarm_res = level_alarm_q;
        rep.relay_alarm = relay_alarm_q;
        rep.alarm_state = (level_alarm_q > relay_alarm_q) ? level_alarm_q : relay_alarm_q;
        rep.alarm_changed = (level_alarm_q != old_level) || (relay_alarm_q != old_relay);
        return rep;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            REG_AVERAGING_COUNT:   shadow_avg_count = v[AVG_CNT_W-1:0];
            REG_LEVEL_TOP:         shadow_top = v[LVL_W-1:0];
            REG_LEVEL_ALARM:       shadow_alarm = v[LVL_W-1:0];
            REG_LEVEL_WARNING:     shadow_warning = v[LVL_W-1:0];
            REG_LEVEL_NORMAL_HIGH: shadow_normal_high = v[LVL_W-1:0];
            REG_HYSTERESIS:        shadow_hyst = v[HYST_W-1:0];
            default:               ;
        endcase
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    task automatic set_all_regs(input int count, input int top, input int alarm,
                                input int warning, input int normal_high, input int hyst);
        write_reg(REG_AVERAGING_COUNT, count);
        write_reg(REG_LEVEL_TOP, top);
        write_reg(REG_LEVEL_ALARM, alarm);
        write_reg(REG_LEVEL_WARNING, warning);
        write_reg(REG_LEVEL_NORMAL_HIGH, normal_high);
        write_reg(REG_HYSTERESIS, hyst);
    endtask

    task automatic queue_sample(input int level, input int adc, input logic [2:0] relays);
        item_t smp;
        smp.level_sample = LVL_W'(level);
        smp.adc_sample = ADC_W'(adc);
        smp.relay_top = relays[2];
        smp.relay_high = relays[1];
        smp.relay_low = relays[0];
        samples_to_send.push_back(smp);
        samples_queued++;
    endtask

    task automatic wait_for_reports();
        while (reports_seen < samples_queued)
        begin
            @(posedge clk);
        end
    endtask

    // Input driver: one new beat per handshake, random gaps and occasional full drains.
    always @(negedge clk)
    begin : drive_blk
        logic  next_valid;
        item_t next_data;
        next_valid = in_valid;
        next_data = in_data;
        if (!rst_n)
        begin
            next_valid = 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            next_valid = 1'b0;
            if (in_taken && (samples_taken % 97 == 0 || $urandom_range(0, 99) == 0))
            begin
                drain_pending = 1'b1;
            end
            if (drain_pending && reports_seen >= samples_taken)
            begin
                drain_pending = 1'b0;
            end
            if (!drain_pending)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (samples_to_send.size() > 0)
                begin
                    next_data = samples_to_send.pop_front();
                    next_valid = 1'b1;
                    send_gap = pick_gap();
                end
            end
        end
        in_valid <= next_valid;
        in_data <= next_data;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin : monitor_blk
        result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
        begin
            in_taken = rst_n && in_valid && in_ready;
            if (rst_n && out_valid && out_ready)
            begin
                reports_seen++;
                if (alarm_reports_due.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("unexpected result beat at cycle %0d", cycle_count);
                    end
                end
                else
                begin
                    want = alarm_reports_due.pop_front();
                    if (out_data !== want)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("mismatch at cycle %0d: exp vld=%0d lvl=%0d adc=%0d la=%0d",
                                     cycle_count, want.average_valid, want.level_average,
                                     want.adc_average, want.level_alarm_res);
                            $display("  exp ra=%0d st=%0d chg=%0d mov=%0d",
                                     want.relay_alarm, want.alarm_state, want.alarm_changed,
                                     want.level_moved);
                            $display("  got vld=%0d lvl=%0d adc=%0d la=%0d ra=%0d st=%0d",
                                     out_data.average_valid, out_data.level_average,
                                     out_data.adc_average, out_data.level_alarm_res,
                                     out_data.relay_alarm, out_data.alarm_state);
                            $display("  got chg=%0d mov=%0d",
                                     out_data.alarm_changed, out_data.level_moved);
                        end
                    end
                end
            end
            if (in_taken)
            begin
                alarm_reports_due.push_back(advance_level_monitor(in_data));
                samples_taken++;
            end
        end
    end

    initial
    begin : stimulus_blk
        int phase;
        int k;
        int r;
        int walk;
        int lo;
        int hi;
        int base;
        int count;
        int top;
        int alarm;
        int warning;
        int normal_high;
        int hyst;
        int level;
        int adc;
        int levels[8];
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default registers: the level alarm stays at zero until the first block completes.
        for (k = 0; k < 10; k++)
        begin
            queue_sample((k % 2) ? 0 : 2047, (k % 2) ? 0 : 4095, 3'(k));
        end
        wait_for_reports();

        // Single-sample blocks walking the ladder, with hysteresis holds and releases.
        write_reg(REG_AVERAGING_COUNT, 1);
        levels = '{201, 199, 195, 401, 398, 395, 396, 345};
        for (k = 0; k < 8; k++)
        begin
            queue_sample(levels[k], 37 * k, 3'(k + 3));
        end
        wait_for_reports();

        // Count lowered in the middle of a block.
        write_reg(REG_AVERAGING_COUNT, 8);
        queue_sample(500, 1000, 3'b111);
        queue_sample(600, 2000, 3'b011);
        queue_sample(700, 3000, 3'b101);
        wait_for_reports();
        write_reg(REG_AVERAGING_COUNT, 2);
        queue_sample(800, 4000, 3'b110);
        wait_for_reports();

        // Count of zero, writes to unused indexes, and a threshold below the hysteresis.
        write_reg(REG_AVERAGING_COUNT, 0);
        write_reg(3'd6, 11'h7FF);
        write_reg(3'd7, 11'h555);
        write_reg(REG_LEVEL_TOP, 0);
        write_reg(REG_HYSTERESIS, 255);
        queue_sample(1, 4095, 3'b000);
        queue_sample(0, 0, 3'b111);
        queue_sample(2047, 2048, 3'b010);
        wait_for_reports();

        for (phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:       count = 11'h7FF;
                1:       count = 64;
                2:       count = 0;
                7:       count = 1;
                default: count = $urandom_range(1, 6);
            endcase
            if (phase == 3)
            begin
                top = 2047;
                alarm = 2047;
                warning = 2047;
                normal_high = 2047;
                hyst = 0;
            end
            else if (phase == 4)
            begin
                top = 0;
                alarm = 0;
                warning = 0;
                normal_high = 0;
                hyst = 255;
            end
            else if (phase == 5)
            begin
                top = $urandom_range(0, 2047);
                alarm = $urandom_range(0, 2047);
                warning = $urandom_range(0, 2047);
                normal_high = $urandom_range(0, 2047);
                hyst = $urandom_range(0, 255);
            end
            else
            begin
                base = $urandom_range(0, 1500);
                normal_high = base;
                warning = normal_high + $urandom_range(0, 150);
                alarm = warning + $urandom_range(0, 150);
                top = alarm + $urandom_range(0, 150);
                hyst = (phase == 6) ? 255 : $urandom_range(0, 255);
            end
            set_all_regs(count, top, alarm, warning, normal_high, hyst);
            write_reg(3'd6 + 3'($urandom_range(0, 1)), $urandom_range(0, 2047));
            no_idle = (phase == 2 || phase == 6);

            lo = (normal_high > 60) ? normal_high - 60 : 0;
            hi = (top < 1987) ? top + 60 : 2047;
            if (lo > hi)
            begin
                lo = 0;
                hi = 2047;
            end
            walk = $urandom_range(lo, hi);
            for (k = 0; k < 125; k++)
            begin
                r = $urandom_range(0, 99);
                walk = walk + int'($urandom_range(0, 80)) - 40;
                if (walk < lo)
                begin
                    walk = lo;
                end
                if (walk > hi)
                begin
                    walk = hi;
                end
                if (r < 15)
                begin
                    level = $urandom_range(0, 2047);
                end
                else if (r < 18)
                begin
                    level = 0;
                end
                else if (r < 21)
                begin
                    level = 2047;
                end
                else
                begin
                    level = walk;
                end
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    adc = 0;
                end
                else if (r < 20)
                begin
                    adc = 4095;
                end
                else
                begin
                    adc = $urandom_range(0, 4095);
                end
                queue_sample(level, adc, 3'($urandom_range(0, 7)));
            end
            wait_for_reports();
        end

        repeat (40) @(posedge clk);
        if (alarm_reports_due.size() != 0)
        begin
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/alam_pkg.sv
rtl/core/alam_front.sv
rtl/core/alam_fifo.sv
rtl/core/alam_back.sv
rtl/core/averaged_level_alarm_monitor_core.sv
rtl/core/alam_checker.sv
tb/sv/tb.sv
